// ===== rtl/pixel_window_level_gray_map_core_assert.svh =====
`ifndef PIXEL_WINDOW_LEVEL_GRAY_MAP_CORE_ASSERT_SVH
`define PIXEL_WINDOW_LEVEL_GRAY_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PWLG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PWLG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwlg_pkg.sv =====
package pwlg_pkg;

    localparam int DEF_MAX_LEVELS = 128;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_AW         = 5;

    localparam logic [2:0] REG_CELL_COUNT = 3'd0;
    localparam logic [2:0] REG_WINDOW_MIN = 3'd1;
    localparam logic [2:0] REG_WINDOW_MAX = 3'd2;
    localparam logic [2:0] REG_RAMP_LOW   = 3'd3;
    localparam logic [2:0] REG_RAMP_HIGH  = 3'd4;

    localparam logic [7:0]         RST_CELL_COUNT = 8'd128;
    localparam logic signed [15:0] RST_WINDOW_MIN = 16'sd0;
    localparam logic signed [15:0] RST_WINDOW_MAX = 16'sd32767;
    localparam logic [7:0]         RST_RAMP_LOW   = 8'd0;
    localparam logic [7:0]         RST_RAMP_HIGH  = 8'd128;

    localparam logic [15:0] GRAY_FULL = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_DIV,
        KIND_ZERO,
        KIND_TOP
    } t_kind;

    typedef struct packed {
        logic [15:0] den_mag;
        logic        den_neg;
        logic        den_zero;
    } t_win_cfg;

    typedef logic [255:0][15:0] t_step_tab;

    // Full-scale gray value divided by every possible ramp width.
    function automatic t_step_tab f_step_tab();
        t_step_tab   tab;
        logic [8:0]  rem;
        logic [15:0] quo;
        tab = '0;
        for (int d = 1; d < 256; d++) begin
            rem = '0;
            quo = '0;
            for (int b = 15; b >= 0; b--) begin
                rem = {rem[7:0], GRAY_FULL[b]};
                if (rem >= 9'(d)) begin
                    rem    = rem - 9'(d);
                    quo[b] = 1'b1;
                end
            end
            tab[d] = quo;
        end
        return tab;
    endfunction

    localparam t_step_tab STEP_TAB = f_step_tab();

endpackage

// ===== rtl/pwlg_front.sv =====
module pwlg_front #(
    parameter int MAX_LEVELS = pwlg_pkg::DEF_MAX_LEVELS,
    localparam int CW = $clog2(MAX_LEVELS + 1),
    localparam int AW = CW + pwlg_pkg::SAMPLE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_sample,
    input  logic signed [15:0]   i_window_min,
    input  logic [CW-1:0]        i_neff,
    input  pwlg_pkg::t_win_cfg   i_win,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pwlg_pkg::t_kind      o_kind,
    output logic [AW-1:0]        o_num
);
    import pwlg_pkg::*;

    logic          r_v1;
    logic          r_neg1;
    logic [15:0]   r_mag1;
    logic          r_v2;
    t_kind         r_kind2;
    logic [AW-1:0] r_num2;

    logic          en1;
    logic          en2;
    logic [16:0]   n_dpos;
    logic [16:0]   n_dneg;
    logic [15:0]   n_mag1;
    t_kind         n_kind2;
    logic [AW-1:0] n_num2;

    assign en2     = ~r_v2 | i_ready;
    assign en1     = ~r_v1 | en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_kind  = r_kind2;
    assign o_num   = r_num2;

    always_comb begin
        n_dpos = {i_sample[15], i_sample} - {i_window_min[15], i_window_min};
        n_dneg = {i_window_min[15], i_window_min} - {i_sample[15], i_sample};
        n_mag1 = n_dpos[16] ? n_dneg[15:0] : n_dpos[15:0];
    end

    always_comb begin
        n_num2 = AW'(i_neff) * AW'(r_mag1);
        priority if (i_neff == '0) begin
            n_kind2 = KIND_ZERO;
        end else if (i_win.den_zero) begin
            n_kind2 = r_neg1 ? KIND_ZERO : KIND_TOP;
        end else if (r_mag1 == '0 || r_neg1 != i_win.den_neg) begin
            n_kind2 = KIND_ZERO;
        end else begin
            n_kind2 = KIND_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_neg1 <= n_dpos[16];
            r_mag1 <= n_mag1;
        end
        if (en2) begin
            r_kind2 <= n_kind2;
            r_num2  <= n_num2;
        end
    end

endmodule

// ===== rtl/pwlg_div.sv =====
module pwlg_div #(
    parameter int MAX_LEVELS = pwlg_pkg::DEF_MAX_LEVELS,
    localparam int CW = $clog2(MAX_LEVELS + 1),
    localparam int QW = $clog2(MAX_LEVELS),
    localparam int AW = CW + pwlg_pkg::SAMPLE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pwlg_pkg::t_kind   i_kind,
    input  logic [AW-1:0]     i_num,
    input  logic [CW-1:0]     i_neff,
    input  logic [15:0]       i_den_mag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [QW-1:0]     o_index
);
    import pwlg_pkg::*;

    logic [QW+1:0] r_v;
    logic [AW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    t_kind         r_kind [0:QW];
    logic [QW-1:0] r_index;

    logic [QW+1:0] en;
    logic [AW-1:0] n_rem  [1:QW];
    logic [QW-1:0] n_q    [1:QW];
    t_kind         n_kind0;
    logic [QW-1:0] n_top;
    logic [QW-1:0] n_index;

    assign en      = ~r_v | {i_ready, en[QW+1:1]};
    assign o_ready = en[0];
    assign o_valid = r_v[QW+1];
    assign o_index = r_index;

    always_comb begin
        if (i_kind == KIND_DIV && i_num >= (AW'(i_den_mag) << QW)) begin
            n_kind0 = KIND_TOP;
        end else begin
            n_kind0 = i_kind;
        end
    end

    always_comb begin
        logic [AW-1:0] bsh;
        for (int j = 1; j <= QW; j++) begin
            bsh      = AW'(i_den_mag) << (QW - j);
            n_rem[j] = r_rem[j-1];
            n_q[j]   = r_q[j-1];
            if (r_rem[j-1] >= bsh) begin
                n_rem[j]      = r_rem[j-1] - bsh;
                n_q[j][QW-j]  = 1'b1;
            end
        end
    end

    always_comb begin
        n_top = QW'(i_neff - CW'(1));
        unique case (r_kind[QW])
            KIND_ZERO: n_index = '0;
            KIND_TOP:  n_index = n_top;
            KIND_DIV:  n_index = (CW'(r_q[QW]) >= i_neff) ? n_top : r_q[QW];
            default:   n_index = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~en) | ({r_v[QW:0], i_valid} & en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= i_num;
            r_q[0]    <= '0;
            r_kind[0] <= n_kind0;
        end
        for (int j = 1; j <= QW; j++) begin
            if (en[j]) begin
                r_rem[j]  <= n_rem[j];
                r_q[j]    <= n_q[j];
                r_kind[j] <= r_kind[j-1];
            end
        end
        if (en[QW+1]) begin
            r_index <= n_index;
        end
    end

endmodule

// ===== rtl/pwlg_ramp.sv =====
module pwlg_ramp #(
    parameter int MAX_LEVELS = pwlg_pkg::DEF_MAX_LEVELS,
    localparam int QW = $clog2(MAX_LEVELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [QW-1:0] i_index,
    input  logic [7:0]    i_ramp_low,
    input  logic [7:0]    i_ramp_high,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [6:0]    o_palette_index,
    output logic [15:0]   o_gray_level
);
    import pwlg_pkg::*;

    logic [7:0]  r_lo;
    logic [7:0]  r_hi;
    logic        r_inv;
    logic [15:0] r_step;

    logic        r_v1;
    logic        r_below1;
    logic        r_above1;
    logic [7:0]  r_off1;
    logic [6:0]  r_pidx1;
    logic        r_v2;
    logic [6:0]  r_pidx2;
    logic [15:0] r_gray2;

    logic        en1;
    logic        en2;
    logic [7:0]  n_lo;
    logic [7:0]  n_hi;
    logic        n_inv;
    logic [7:0]  width;
    logic [7:0]  idx;
    logic [23:0] prod;
    logic [15:0] n_ramp;

    assign en2             = ~r_v2 | i_ready;
    assign en1             = ~r_v1 | en2;
    assign o_ready         = en1;
    assign o_valid         = r_v2;
    assign o_palette_index = r_pidx2;
    assign o_gray_level    = r_gray2;

    always_comb begin
        logic [7:0] lo;
        logic [7:0] hi;
        lo = i_ramp_low;
        hi = i_ramp_high;
        if (lo == hi) begin
            if (hi != '0) begin
                lo = hi - 8'd1;
            end else begin
                hi = 8'd1;
            end
        end
        if (hi < lo) begin
            n_lo  = hi;
            n_hi  = lo;
            n_inv = 1'b1;
        end else begin
            n_lo  = lo;
            n_hi  = hi;
            n_inv = 1'b0;
        end
    end

    assign width = r_hi - r_lo;
    assign idx   = 8'(i_index);
    assign prod  = 24'(r_off1) * 24'(r_step);

    always_comb begin
        priority if (r_below1) begin
            n_ramp = '0;
        end else if (r_above1) begin
            n_ramp = GRAY_FULL;
        end else begin
            n_ramp = prod[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_inv  <= n_inv;
        r_step <= STEP_TAB[width];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_below1 <= idx < r_lo;
            r_above1 <= idx >= r_hi;
            r_off1   <= idx - r_lo;
            r_pidx1  <= 7'(i_index);
        end
        if (en2) begin
            r_pidx2 <= r_pidx1;
            r_gray2 <= r_inv ? ~n_ramp : n_ramp;
        end
    end

endmodule

// ===== rtl/pixel_window_level_gray_map_core.sv =====
// Each accepted input word passes the front stages, the one-bit-per-stage quotient pipeline
// and the ramp stages before it leaves as an output word.
// Throughput: one word per cycle; a stage holds only while the next is full and not moving.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
// No clearing pass is needed after reset.
module pixel_window_level_gray_map_core #(
    parameter int MAX_LEVELS = pwlg_pkg::DEF_MAX_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwlg_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic signed [15:0]          s_axis_tdata,   // [15:0] sample
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata    // [6:0] palette_index, [22:7] gray_level
);
    import pwlg_pkg::*;

    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int QW = $clog2(MAX_LEVELS);
    localparam int AW = CW + SAMPLE_W;

    logic [7:0]         r_cell_count;
    logic signed [15:0] r_window_min;
    logic signed [15:0] r_window_max;
    logic [7:0]         r_ramp_low;
    logic [7:0]         r_ramp_high;
    logic [CW-1:0]      r_neff;
    t_win_cfg           r_win;

    t_win_cfg      n_win;
    logic [CW-1:0] n_neff;
    logic [16:0]   dpos;
    logic [16:0]   dneg;
    logic          f_valid;
    logic          f_ready;
    t_kind         f_kind;
    logic [AW-1:0] f_num;
    logic          d_valid;
    logic          d_ready;
    logic [QW-1:0] d_index;
    logic [6:0]    palette_index;
    logic [15:0]   gray_level;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= RST_CELL_COUNT;
            r_window_min <= RST_WINDOW_MIN;
            r_window_max <= RST_WINDOW_MAX;
            r_ramp_low   <= RST_RAMP_LOW;
            r_ramp_high  <= RST_RAMP_HIGH;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[CFG_AW-1:2])
                REG_CELL_COUNT: r_cell_count <= pwdata[7:0];
                REG_WINDOW_MIN: r_window_min <= pwdata[15:0];
                REG_WINDOW_MAX: r_window_max <= pwdata[15:0];
                REG_RAMP_LOW:   r_ramp_low   <= pwdata[7:0];
                REG_RAMP_HIGH:  r_ramp_high  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[CFG_AW-1:2])
            REG_CELL_COUNT: prdata = 32'(r_cell_count);
            REG_WINDOW_MIN: prdata = 32'(r_window_min);
            REG_WINDOW_MAX: prdata = 32'(r_window_max);
            REG_RAMP_LOW:   prdata = 32'(r_ramp_low);
            REG_RAMP_HIGH:  prdata = 32'(r_ramp_high);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        dpos           = {r_window_max[15], r_window_max} - {r_window_min[15], r_window_min};
        dneg           = {r_window_min[15], r_window_min} - {r_window_max[15], r_window_max};
        n_win.den_neg  = dpos[16];
        n_win.den_mag  = dpos[16] ? dneg[15:0] : dpos[15:0];
        n_win.den_zero = (r_window_max == r_window_min);
        n_neff         = (int'(r_cell_count) > MAX_LEVELS) ? CW'(MAX_LEVELS)
                                                          : CW'(r_cell_count);
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_neff <= n_neff;
    end

    pwlg_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata),
        .i_window_min (r_window_min),
        .i_neff       (r_neff),
        .i_win        (r_win),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_kind       (f_kind),
        .o_num        (f_num)
    );

    pwlg_div #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_valid),
        .o_ready   (f_ready),
        .i_kind    (f_kind),
        .i_num     (f_num),
        .i_neff    (r_neff),
        .i_den_mag (r_win.den_mag),
        .o_valid   (d_valid),
        .i_ready   (d_ready),
        .o_index   (d_index)
    );

    pwlg_ramp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_ramp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (d_valid),
        .o_ready         (d_ready),
        .i_index         (d_index),
        .i_ramp_low      (r_ramp_low),
        .i_ramp_high     (r_ramp_high),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_palette_index (palette_index),
        .o_gray_level    (gray_level)
    );

    assign m_axis_tdata = {1'b0, gray_level, palette_index};

endmodule

// ===== rtl/pwlg_checker.sv =====
`include "pixel_window_level_gray_map_core_assert.svh"

module pwlg_checker #(
    parameter int MAX_LEVELS = pwlg_pkg::DEF_MAX_LEVELS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    localparam int DEPTH = $clog2(MAX_LEVELS) + 6;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign out_acc = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    `PWLG_ASSERT_IMPLY(a_no_extra_word, i_clk, i_rst_n, m_axis_tvalid, r_cnt != '0, "output word without an input word in flight")
    `PWLG_ASSERT_IMPLY(a_depth_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH), "more words in flight than pipeline stages")
    `PWLG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

endmodule

bind pixel_window_level_gray_map_core pwlg_checker #(
    .MAX_LEVELS (MAX_LEVELS)
) u_pwlg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/pixel_window_level_gray_map_core_tb.sv =====
`timescale 1ns / 100ps

module pixel_window_level_gray_map_core_tb;
    import pwlg_pkg::*;

    localparam int LEVELS       = DEF_MAX_LEVELS;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 140;

    typedef struct packed {
        logic [6:0]  index;
        logic [15:0] gray;
    } t_gray_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [CFG_AW-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [15:0] s_axis_tdata = '0;   // [15:0] sample
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;        // [6:0] palette_index, [22:7] gray_level

    logic [7:0]         cells_cfg = RST_CELL_COUNT;
    logic signed [15:0] wmin_cfg  = RST_WINDOW_MIN;
    logic signed [15:0] wmax_cfg  = RST_WINDOW_MAX;
    logic [7:0]         rlow_cfg  = RST_RAMP_LOW;
    logic [7:0]         rhigh_cfg = RST_RAMP_HIGH;

    logic signed [15:0] sample_q[$];
    t_gray_word         gray_expect_q[$];
    logic               in_fire = 1'b0;
    int                 src_idle_pct = 0;
    int                 sink_idle_pct = 0;
    int                 err_count = 0;
    int                 n_samples = 0;
    int                 n_words = 0;
    int                 n_writes = 0;
    int                 stall_cycles = 0;

    pixel_window_level_gray_map_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_gray_word map_sample(input logic signed [15:0] s);
        t_gray_word w;
        int         n;
        int         den;
        int         q;
        int         lo;
        int         hi;
        int         tmp;
        int         stp;
        int         f;
        bit         inv;
        n = int'(cells_cfg);
        if (n > LEVELS) n = LEVELS;
        den = int'(wmax_cfg) - int'(wmin_cfg);
        if (n == 0) begin
            q = 0;
        end else if (den == 0) begin
            q = (s >= wmin_cfg) ? n - 1 : 0;
        end else begin
            q = (n * (int'(s) - int'(wmin_cfg))) / den;
            if (q >= n) q = n - 1;
            if (q < 0) q = 0;
        end
        lo  = int'(rlow_cfg);
        hi  = int'(rhigh_cfg);
        inv = 1'b0;
        if (hi == lo) begin
            if (hi > 0) lo = hi - 1;
            else hi = lo + 1;
        end
        if (hi < lo) begin
            tmp = hi;
            hi  = lo;
            lo  = tmp;
            inv = 1'b1;
        end
        stp = 65535 / (hi - lo);
        if (q < lo) f = 0;
        else if (q < hi) f = (q - lo) * stp;
        else f = 65535;
        if (inv) f = 65535 - f;
        w.index = 7'(q);
        w.gray  = 16'(f);
        return w;
    endfunction

    function automatic logic signed [15:0] random_sample();
        int wlo;
        int whi;
        int v;
        wlo = (wmin_cfg < wmax_cfg) ? int'(wmin_cfg) : int'(wmax_cfg);
        whi = (wmin_cfg < wmax_cfg) ? int'(wmax_cfg) : int'(wmin_cfg);
        case ($urandom_range(0, 9))
            0: begin
                v = $urandom_range(0, 1) ? 32767 : -32768;
            end
            1: begin
                v = int'(wmin_cfg) + int'($urandom_range(0, 6)) - 3;
            end
            2: begin
                v = int'(wmax_cfg) + int'($urandom_range(0, 6)) - 3;
            end
            3, 4, 5: begin
                v = int'($urandom_range(0, 65535)) - 32768;
            end
            default: begin
                v = wlo + int'($urandom_range(0, whi - wlo));
            end
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CELL_COUNT: cells_cfg = val[7:0];
            REG_WINDOW_MIN: wmin_cfg  = val[15:0];
            REG_WINDOW_MAX: wmax_cfg  = val[15:0];
            REG_RAMP_LOW:   rlow_cfg  = val[7:0];
            REG_RAMP_HIGH:  rhigh_cfg = val[7:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || gray_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Sender side: a word stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_axis_tdata  <= sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_gray_word want;
        if (!i_rst_n) begin
            in_fire      <= 1'b0;
            stall_cycles = 0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                gray_expect_q.push_back(map_sample(s_axis_tdata));
                n_samples++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_words++;
                if (gray_expect_q.size() == 0) begin
                    $display("%0t: output word with no sample pending", $realtime);
                    err_count++;
                end else begin
                    want = gray_expect_q.pop_front();
                    if (m_axis_tdata[6:0] !== want.index)
                        report_mismatch("palette_index", m_axis_tdata[6:0], want.index);
                    if (m_axis_tdata[22:7] !== want.gray)
                        report_mismatch("gray_level", m_axis_tdata[22:7], want.gray);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (sample_q.size() == 0 && !s_axis_tvalid && gray_expect_q.size() == 0))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int                 dir_cells[6] = '{128, 1, 0, 255, 64, 16};
        int                 dir_wmin[6]  = '{-32768, 100, 32767, -1000, 500, -32768};
        int                 dir_wmax[6]  = '{32767, 100, -32768, 1000, -500, -32768};
        int                 dir_rlow[6]  = '{0, 5, 0, 127, 200, 128};
        int                 dir_rhigh[6] = '{127, 5, 0, 0, 255, 128};
        logic signed [15:0] edge_samples[11] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1,
            16'sd255, 16'sd256, 16'sd16383, 16'sd32766, 16'sd32767, 16'sh5555, 16'shAAAA};
        int                 cw;
        int                 wl;
        int                 wh;
        int                 rl;
        int                 rh;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            if (p >= 1 && p <= 6) begin
                cw = dir_cells[p-1];
                wl = dir_wmin[p-1];
                wh = dir_wmax[p-1];
                rl = dir_rlow[p-1];
                rh = dir_rhigh[p-1];
            end else if (p > 6) begin
                cw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 128);
                wl = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1)) begin
                    wh = wl + int'($urandom_range(0, 4000)) - 2000;
                    if (wh > 32767) wh = 32767;
                    if (wh < -32768) wh = -32768;
                end else begin
                    wh = int'($urandom_range(0, 65535)) - 32768;
                end
                rl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 128);
                rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 128);
            end
            if (p >= 1) begin
                write_reg(REG_CELL_COUNT, 32'(cw & 8'hFF));
                write_reg(REG_WINDOW_MIN, 32'(wl & 16'hFFFF));
                write_reg(REG_WINDOW_MAX, 32'(wh & 16'hFFFF));
                write_reg(REG_RAMP_LOW, 32'(rl & 8'hFF));
                write_reg(REG_RAMP_HIGH, 32'(rh & 8'hFF));
            end
            @(posedge i_clk);
            if (p < 4) begin
                src_idle_pct  = 8;
                sink_idle_pct = 46;
            end else if (p < 7) begin
                src_idle_pct  = 46;
                sink_idle_pct = 8;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (p == 0)
                foreach (edge_samples[k]) sample_q.push_back(edge_samples[k]);
            for (int k = 0; k < PHASE_ITEMS; k++)
                sample_q.push_back(random_sample());
            wait_drained();
        end
        $display("Mapped %0d samples into %0d output words across %0d window and ramp settings.",
                 n_samples, n_words, PHASES);
        $display("Made %0d register writes; %0d mismatches found.", n_writes, err_count);
        if (err_count == 0 && gray_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
